/* hdl/bmc_pkg.sv */
// Package with the opcode, register address and flag constants of the baseline core.
`default_nettype none
package bmc_pkg;
	localparam int unsigned FLAG_C  = 0;
	localparam int unsigned FLAG_DC = 1;
	localparam int unsigned FLAG_Z  = 2;
	localparam int unsigned FLAG_PD = 3;
	localparam int unsigned FLAG_TO = 4;

	localparam logic [7:0] STATUS_RESET = 8'h18;
	localparam logic [5:0] OPTION_RESET = 6'h3f;
	localparam logic [3:0] TRIS_A_RESET = 4'hf;
	localparam logic [7:0] TRIS_B_RESET = 8'hff;

	localparam logic [4:0] ADDR_INDF   = 5'd0;
	localparam logic [4:0] ADDR_TMR0   = 5'd1;
	localparam logic [4:0] ADDR_PCL    = 5'd2;
	localparam logic [4:0] ADDR_STATUS = 5'd3;
	localparam logic [4:0] ADDR_FSR    = 5'd4;
	localparam logic [4:0] ADDR_PORTA  = 5'd5;
	localparam logic [4:0] ADDR_PORTB  = 5'd6;

	localparam logic [7:0] SPC_OPTION = 8'd2;
	localparam logic [7:0] SPC_SLEEP  = 8'd3;
	localparam logic [7:0] SPC_CLRWDT = 8'd4;
	localparam logic [7:0] SPC_TRISA  = 8'd5;
	localparam logic [7:0] SPC_TRISB  = 8'd6;

	typedef enum logic [3:0] {
		OP_SUBWF = 4'd2, OP_DECF = 4'd3, OP_IORWF = 4'd4, OP_ANDWF = 4'd5,
		OP_XORWF = 4'd6, OP_ADDWF = 4'd7, OP_MOVF = 4'd8, OP_COMF = 4'd9,
		OP_INCF = 4'd10, OP_DECFSZ = 4'd11, OP_RRF = 4'd12, OP_RLF = 4'd13,
		OP_SWAPF = 4'd14, OP_INCFSZ = 4'd15
	} alu_op_t;

	localparam logic [3:0] OPH_BCF   = 4'd4;
	localparam logic [3:0] OPH_BSF   = 4'd5;
	localparam logic [3:0] OPH_BTFSC = 4'd6;
	localparam logic [3:0] OPH_BTFSS = 4'd7;
	localparam logic [3:0] OPH_RETLW = 4'd8;
	localparam logic [3:0] OPH_CALL  = 4'd9;
	localparam logic [3:0] OPH_GOTOL = 4'd10;
	localparam logic [3:0] OPH_GOTOH = 4'd11;
	localparam logic [3:0] OPH_MOVLW = 4'd12;
	localparam logic [3:0] OPH_IORLW = 4'd13;
	localparam logic [3:0] OPH_ANDLW = 4'd14;
	localparam logic [3:0] OPH_XORLW = 4'd15;
endpackage
`default_nettype wire

/* hdl/baseline_microcontroller_core.sv */
// Top level of the baseline 12-bit microcontroller core.
// The core executes one instruction per input word on the s_axis channel. The word
// carries the instruction together with the pin levels and the timer value that
// the instruction sees. Each accepted word produces exactly one result word on
// m_axis with the next fetch address and the visible registers.
// Two stages: stage one accepts the word and reads the register file memory
// at the decoded address; stage two reads, modifies and writes back, and loads
// the output register. A word is accepted every cycle, one instruction per
// clock, when the output side keeps up. A write in stage two to the entry read
// in stage one of the next word is forwarded, as are FSR and all core registers,
// which live in flip-flops updated by stage two.
// The return stack is kept in flip-flops, indexed by the stack level.
// Reset clears the register file to zero by a valid bit per entry, loads STATUS
// with TO and PD set and the direction and OPTION registers with all ones.
// When m_axis stalls, the result holds; a skid register holds one more, and
// s_axis_tready falls when the skid register is full, or when m_axis stalls
// while both the output register and stage two hold a word.
`default_nettype none
module baseline_microcontroller_core
	import bmc_pkg::*;
#(
	parameter int PROGRAM_WORDS = 512,
	parameter int FILE_BYTES = 32,
	parameter int RETURN_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// instruction_word[11:0], port_a_pins[15:12], port_b_pins[23:16], timer_count[31:24]
	input  wire logic [31:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// next_pc[8:0], w_value[16:9], port_a_latch[20:17], port_b_latch[28:21],
	// tris_a_value[32:29], tris_b_value[40:33], option_value[46:41],
	// timer_write_valid[47], timer_write_data[55:48], sleeping[56], zero[63:57]
	output logic [63:0]      m_axis_tdata
);
	localparam int LW = (RETURN_DEPTH > 1) ? $clog2(RETURN_DEPTH) : 1;
	localparam int SW = $clog2(RETURN_DEPTH + 1);

	logic [7:0] mem [FILE_BYTES];
	logic [FILE_BYTES-1:0] vld_q;
	logic [7:0] rd_s2;
	logic rdv_s2;

	logic [8:0] pc_q;
	logic [7:0] w_q, fsr_q, status_q, latb_q, trisb_q;
	logic [3:0] lata_q, trisa_q;
	logic [5:0] opt_q;
	logic sleep_q;
	logic [8:0] stk_q [RETURN_DEPTH];
	logic [SW-1:0] lvl_q;

	logic v_s2;
	logic [31:0] d_s2;
	logic [4:0] a_s2;
	logic ok_s2;

	logic ov_q, sk_q;
	logic [63:0] od_q, skd_q;

	logic adv;
	assign s_axis_tready = !sk_q && !(ov_q && v_s2 && !m_axis_tready);
	assign adv = s_axis_tvalid && s_axis_tready;

	logic wen;
	logic [4:0] wad;
	logic [7:0] wdat;
	logic [7:0] fsr_n;

	// forwarded read data replaces a stale memory read
	logic [7:0] fwd_d_s2;
	logic fwd_s2;

	// stage one address: uses forwarded FSR
	logic [11:0] ins1;
	logic [4:0] ra1;
	logic ok1;
	always_comb begin
		ins1 = s_axis_tdata[11:0];
		ra1 = ins1[4:0];
		if (ra1 == ADDR_INDF)
			ra1 = fsr_n[4:0];
		ok1 = (ra1 != ADDR_INDF) && (32'(ra1) < FILE_BYTES);
	end

	always_ff @(posedge clk) begin
		if (wen)
			mem[wad[$clog2(FILE_BYTES)-1:0]] <= wdat;
		if (adv)
			rd_s2 <= mem[ra1[$clog2(FILE_BYTES)-1:0]];
	end

	// stage two
	logic [11:0] ins;
	logic [7:0] fv, r, k, m, w_n, st_n, latb_n, trisb_n;
	logic [3:0] lata_n, trisa_n;
	logic [5:0] opt_n;
	logic [3:0] op;
	logic [1:0] grp;
	logic tof, skip, jumped, zset, dofw, sleep_n, tsv;
	logic [7:0] tsd, fwv;
	logic [8:0] pc1, base, npc, pcl_t;
	logic pclw;
	logic [SW-1:0] lvl_n;
	logic push, pop;
	logic [8:0] cur;
	logic [8:0] sum;
	alu_op_t code;

	always_comb begin
		ins = d_s2[11:0];
		op = ins[11:8];
		grp = ins[7:6];
		tof = ins[5];
		k = ins[7:0];
		m = 8'd1 << ins[7:5];
		code = alu_op_t'({op[1:0], grp});
		pc1 = (32'(pc_q) + 1 >= PROGRAM_WORDS) ? 9'd0 : pc_q + 9'd1;
		cur = pc1;
		if (!ok_s2)
			fv = 8'd0;
		else begin
			case (a_s2)
				ADDR_TMR0: fv = d_s2[31:24];
				ADDR_PCL: fv = pc1[7:0];
				ADDR_STATUS: fv = status_q;
				ADDR_FSR: fv = fsr_q;
				ADDR_PORTA: fv = {4'd0, d_s2[15:12]};
				ADDR_PORTB: fv = d_s2[23:16];
				default: fv = fwd_s2 ? fwd_d_s2 : (rdv_s2 ? rd_s2 : 8'd0);
			endcase
		end
		skip = 1'b0; jumped = 1'b0; zset = 1'b0; dofw = 1'b0; fwv = 8'd0; r = 8'd0;
		w_n = w_q; st_n = status_q; lata_n = lata_q; latb_n = latb_q;
		trisa_n = trisa_q; trisb_n = trisb_q; opt_n = opt_q; sleep_n = sleep_q;
		base = 9'd0; push = 1'b0; pop = 1'b0; sum = 9'd0;
		if (op <= 4'd3) begin
			if (op == 4'd0 && grp == 2'd0) begin
				if (tof) begin
					dofw = 1'b1; fwv = w_q;
				end else begin
					case (k)
						SPC_OPTION: opt_n = w_q[5:0];
						SPC_SLEEP: begin
							st_n[FLAG_TO] = 1'b1; st_n[FLAG_PD] = 1'b0; sleep_n = 1'b1;
						end
						SPC_CLRWDT: begin
							st_n[FLAG_TO] = 1'b1; st_n[FLAG_PD] = 1'b1;
						end
						SPC_TRISA: trisa_n = w_q[3:0];
						SPC_TRISB: trisb_n = w_q;
						default: ;
					endcase
				end
			end else if (op == 4'd0 && grp == 2'd1) begin
				if (tof) begin
					dofw = 1'b1; fwv = 8'd0;
				end else
					w_n = 8'd0;
			end else begin
				zset = 1'b1;
				case (code)
					OP_SUBWF: begin
						sum = {1'b0, fv} - {1'b0, w_q}; r = sum[7:0];
					end
					OP_DECF: r = fv - 8'd1;
					OP_IORWF: r = fv | w_q;
					OP_ANDWF: r = fv & w_q;
					OP_XORWF: r = fv ^ w_q;
					OP_ADDWF: begin
						sum = {1'b0, fv} + {1'b0, w_q}; r = sum[7:0];
					end
					OP_MOVF: r = fv;
					OP_COMF: r = ~fv;
					OP_INCF: r = fv + 8'd1;
					OP_DECFSZ: begin
						r = fv - 8'd1; skip = (r == 8'd0); zset = 1'b0;
					end
					OP_RRF: begin
						r = {status_q[FLAG_C], fv[7:1]}; zset = 1'b0;
					end
					OP_RLF: begin
						r = {fv[6:0], status_q[FLAG_C]}; zset = 1'b0;
					end
					OP_SWAPF: begin
						r = {fv[3:0], fv[7:4]}; zset = 1'b0;
					end
					default: begin
						r = fv + 8'd1; skip = (r == 8'd0); zset = 1'b0;
					end
				endcase
				if (tof) begin
					dofw = 1'b1; fwv = r;
				end else
					w_n = r;
			end
		end else if (op <= OPH_BTFSS) begin
			case (op)
				OPH_BCF: begin
					dofw = 1'b1; fwv = fv & ~m;
				end
				OPH_BSF: begin
					dofw = 1'b1; fwv = fv | m;
				end
				OPH_BTFSC: skip = ((fv & m) == 8'd0);
				default: skip = ((fv & m) != 8'd0);
			endcase
		end else begin
			case (op)
				OPH_RETLW: begin
					w_n = k; jumped = 1'b1; pop = 1'b1;
				end
				OPH_CALL: begin
					push = 1'b1; base = {1'b0, k}; jumped = 1'b1;
				end
				OPH_GOTOL, OPH_GOTOH: begin
					base = ins[8:0]; jumped = 1'b1;
				end
				OPH_MOVLW: w_n = k;
				OPH_IORLW: w_n = w_q | k;
				OPH_ANDLW: w_n = w_q & k;
				default: w_n = w_q ^ k;
			endcase
		end
		// file write side effects
		wen = 1'b0; wad = a_s2; wdat = fwv; tsv = 1'b0; tsd = 8'd0;
		pclw = 1'b0; pcl_t = 9'd0; fsr_n = fsr_q;
		if (v_s2 && dofw && ok_s2) begin
			case (a_s2)
				ADDR_TMR0: begin
					tsv = 1'b1; tsd = fwv;
				end
				ADDR_PCL: begin
					pclw = 1'b1; pcl_t = {1'b0, fwv};
				end
				ADDR_STATUS: st_n = (status_q & 8'h18) | (fwv & 8'he7);
				ADDR_FSR: fsr_n = fwv;
				ADDR_PORTA: lata_n = fwv[3:0];
				ADDR_PORTB: latb_n = fwv;
				default: wen = 1'b1;
			endcase
		end
		// flags
		if (op == 4'd0 && grp == 2'd1)
			st_n[FLAG_Z] = 1'b1;
		if (zset)
			st_n[FLAG_Z] = (r == 8'd0);
		if (op >= OPH_IORLW)
			st_n[FLAG_Z] = (w_n == 8'd0);
		if (op <= 4'd3 && !(op == 4'd0 && grp <= 2'd1)) begin
			if (code == OP_SUBWF) begin
				st_n[FLAG_C] = (fv >= w_q);
				st_n[FLAG_DC] = (fv[3:0] >= w_q[3:0]);
			end else if (code == OP_ADDWF) begin
				st_n[FLAG_C] = sum[8];
				st_n[FLAG_DC] = (5'(fv[3:0]) + 5'(w_q[3:0])) > 5'd15;
			end else if (code == OP_RRF)
				st_n[FLAG_C] = fv[0];
			else if (code == OP_RLF)
				st_n[FLAG_C] = fv[7];
		end
		lvl_n = lvl_q;
		if (pop) begin
			if (lvl_q != '0) begin
				lvl_n = lvl_q - SW'(1);
				base = stk_q[LW'(lvl_n)];
			end else
				base = 9'd0;
		end
		if (push && 32'(lvl_q) < RETURN_DEPTH)
			lvl_n = lvl_q + SW'(1);
		if (!jumped)
			base = pclw ? pcl_t : cur;
		if (32'(base) >= PROGRAM_WORDS)
			base = 9'(32'(base) - PROGRAM_WORDS);
		npc = (skip && (32'(base) + 1 >= PROGRAM_WORDS)) ? 9'd0 : base + {8'd0, skip};
	end

	logic [63:0] res;
	assign res = {7'd0, sleep_n, tsd, tsv, opt_n, trisb_n, trisa_n, latb_n, lata_n, w_n, npc};

	// register file writes forwarded into the same-cycle read by address match
	logic fwd_hit;
	assign fwd_hit = wen && (wad == ra1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			vld_q <= '0;
			rdv_s2 <= 1'b0;
			pc_q <= '0; w_q <= '0; fsr_q <= '0; status_q <= STATUS_RESET;
			lata_q <= '0; latb_q <= '0; trisa_q <= TRIS_A_RESET; trisb_q <= TRIS_B_RESET;
			opt_q <= OPTION_RESET; sleep_q <= 1'b0; lvl_q <= '0;
			for (int i = 0; i < RETURN_DEPTH; i++)
				stk_q[i] <= '0;
			ov_q <= 1'b0; sk_q <= 1'b0;
		end else begin
			v_s2 <= adv;
			if (adv) begin
				d_s2 <= s_axis_tdata;
				a_s2 <= ra1;
				ok_s2 <= ok1;
				rdv_s2 <= vld_q[ra1[$clog2(FILE_BYTES)-1:0]] || fwd_hit;
			end
			if (v_s2) begin
				if (wen)
					vld_q[wad[$clog2(FILE_BYTES)-1:0]] <= 1'b1;
				pc_q <= npc; w_q <= w_n; fsr_q <= fsr_n; status_q <= st_n;
				lata_q <= lata_n; latb_q <= latb_n; trisa_q <= trisa_n;
				trisb_q <= trisb_n; opt_q <= opt_n; sleep_q <= sleep_n; lvl_q <= lvl_n;
				if (push && 32'(lvl_q) < RETURN_DEPTH)
					stk_q[LW'(lvl_q)] <= pc1;
			end
			if (ov_q && m_axis_tready) begin
				ov_q <= sk_q || v_s2;
				sk_q <= 1'b0;
				od_q <= sk_q ? skd_q : res;
				if (sk_q && v_s2) begin
					sk_q <= 1'b1; skd_q <= res;
				end
			end else if (v_s2) begin
				if (!ov_q) begin
					ov_q <= 1'b1; od_q <= res;
				end else begin
					sk_q <= 1'b1; skd_q <= res;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fwd_s2 <= fwd_hit;
			fwd_d_s2 <= wdat;
		end
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata = od_q;

	a_skid: assert property (@(posedge clk) disable iff (!arst_n) sk_q |-> ov_q)
		else $error("skid full while output empty");
	a_lvl: assert property (@(posedge clk) disable iff (!arst_n)
		32'(lvl_q) <= RETURN_DEPTH) else $error("stack level out of range");
	a_sleep: assert property (@(posedge clk) disable iff (!arst_n)
		$past(sleep_q) |-> sleep_q) else $error("sleep flag cleared");
	a_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && fwd_s2) |-> rdv_s2)
		else $error("forwarded entry not marked valid");
endmodule
`default_nettype wire

/* bench/bmc_checker.sv */
// Checker that predicts each result word of the baseline core and compares it.
`timescale 1ns / 1ps
`default_nettype none
module bmc_checker
	import bmc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [63:0] m_axis_tdata,
	output int               errors,
	output int               pending
);
	typedef struct packed {
		logic       sleeping;
		logic [7:0] tmr_data;
		logic       tmr_valid;
		logic [5:0] option;
		logic [7:0] tris_b;
		logic [3:0] tris_a;
		logic [7:0] lat_b;
		logic [3:0] lat_a;
		logic [7:0] w;
		logic [8:0] pc;
	} core_view_t;

	logic [8:0] pc_q;
	logic [7:0] w_q;
	logic [7:0] regs [32];
	logic [7:0] fsr_q;
	logic [7:0] status_q;
	logic [8:0] stack_q [2];
	int         depth_q;
	logic [3:0] lat_a_q, tris_a_q;
	logic [7:0] lat_b_q, tris_b_q;
	logic [5:0] option_q;
	logic       sleep_q;

	core_view_t views_due [$];

	logic [7:0] pins_a, pins_b, timer_in, pc_next_lo;
	logic       tmr_hit, pcl_hit;
	logic [7:0] tmr_val, pcl_val;

	function automatic int map_addr(logic [4:0] f);
		int a;
		a = f;
		if (a == 0) begin
			a = fsr_q[4:0];
			if (a == 0)
				return -1;
		end
		return a;
	endfunction

	function automatic logic [7:0] read_file(logic [4:0] f);
		int a;
		a = map_addr(f);
		case (a)
			-1: return 8'd0;
			ADDR_TMR0: return timer_in;
			ADDR_PCL: return pc_next_lo;
			ADDR_STATUS: return status_q;
			ADDR_FSR: return fsr_q;
			ADDR_PORTA: return {4'd0, pins_a[3:0]};
			ADDR_PORTB: return pins_b;
			default: return regs[a];
		endcase
	endfunction

	task automatic write_file(logic [4:0] f, logic [7:0] v);
		int a;
		a = map_addr(f);
		case (a)
			-1: ;
			ADDR_TMR0: begin
				tmr_hit = 1;
				tmr_val = v;
			end
			ADDR_PCL: begin
				pcl_hit = 1;
				pcl_val = v;
			end
			ADDR_STATUS: status_q = (status_q & 8'h18) | (v & 8'he7);
			ADDR_FSR: fsr_q = v;
			ADDR_PORTA: lat_a_q = v[3:0];
			ADDR_PORTB: lat_b_q = v;
			default: regs[a] = v;
		endcase
	endtask

	task automatic execute_word(logic [31:0] d);
		logic [11:0] ins;
		logic [3:0]  op;
		logic [1:0]  grp;
		logic [4:0]  f;
		logic [7:0]  k, fv, r, w, m;
		logic [8:0]  pc1, target;
		logic        skip, jumped, zset, to_file;
		alu_op_t     code;
		core_view_t  v;
		ins = d[11:0];
		pins_a = {4'd0, d[15:12]};
		pins_b = d[23:16];
		timer_in = d[31:24];
		op = ins[11:8];
		grp = ins[7:6];
		f = ins[4:0];
		k = ins[7:0];
		to_file = ins[5];
		m = 8'd1 << ins[7:5];
		w = w_q;
		skip = 0;
		jumped = 0;
		zset = 1;
		r = 0;
		target = 0;
		tmr_hit = 0;
		tmr_val = 0;
		pcl_hit = 0;
		pcl_val = 0;
		pc1 = pc_q + 9'd1;
		pc_next_lo = pc1[7:0];
		if (op <= 4'd3) begin
			if (op == 0 && grp == 0) begin
				if (to_file)
					write_file(f, w);
				else begin
					case (k)
						SPC_OPTION: option_q = w[5:0];
						SPC_SLEEP: begin
							status_q[FLAG_TO] = 1;
							status_q[FLAG_PD] = 0;
							sleep_q = 1;
						end
						SPC_CLRWDT: begin
							status_q[FLAG_TO] = 1;
							status_q[FLAG_PD] = 1;
						end
						SPC_TRISA: tris_a_q = w[3:0];
						SPC_TRISB: tris_b_q = w;
						default: ;
					endcase
				end
			end else if (op == 0 && grp == 1) begin
				if (to_file)
					write_file(f, 8'd0);
				else
					w_q = 0;
				status_q[FLAG_Z] = 1;
			end else begin
				fv = read_file(f);
				code = alu_op_t'({op[1:0], grp});
				case (code)
					OP_SUBWF: r = fv - w;
					OP_DECF: r = fv - 1;
					OP_IORWF: r = fv | w;
					OP_ANDWF: r = fv & w;
					OP_XORWF: r = fv ^ w;
					OP_ADDWF: r = fv + w;
					OP_MOVF: r = fv;
					OP_COMF: r = ~fv;
					OP_INCF: r = fv + 1;
					OP_DECFSZ: begin
						r = fv - 1;
						skip = (r == 0);
						zset = 0;
					end
					OP_RRF: begin
						r = {status_q[FLAG_C], fv[7:1]};
						zset = 0;
					end
					OP_RLF: begin
						r = {fv[6:0], status_q[FLAG_C]};
						zset = 0;
					end
					OP_SWAPF: begin
						r = {fv[3:0], fv[7:4]};
						zset = 0;
					end
					default: begin
						r = fv + 1;
						skip = (r == 0);
						zset = 0;
					end
				endcase
				if (to_file)
					write_file(f, r);
				else
					w_q = r;
				if (zset)
					status_q[FLAG_Z] = (r == 0);
				case (code)
					OP_SUBWF: begin
						status_q[FLAG_C] = fv >= w;
						status_q[FLAG_DC] = fv[3:0] >= w[3:0];
					end
					OP_ADDWF: begin
						status_q[FLAG_C] = ({1'b0, fv} + {1'b0, w}) > 9'd255;
						status_q[FLAG_DC] = ({1'b0, fv[3:0]} + {1'b0, w[3:0]}) > 5'd15;
					end
					OP_RRF: status_q[FLAG_C] = fv[0];
					OP_RLF: status_q[FLAG_C] = fv[7];
					default: ;
				endcase
			end
		end else begin
			case (op)
				OPH_BCF, OPH_BSF, OPH_BTFSC, OPH_BTFSS: begin
					fv = read_file(f);
					if (op == OPH_BCF)
						write_file(f, fv & ~m);
					else if (op == OPH_BSF)
						write_file(f, fv | m);
					else if (op == OPH_BTFSC)
						skip = (fv & m) == 0;
					else
						skip = (fv & m) != 0;
				end
				OPH_RETLW: begin
					w_q = k;
					jumped = 1;
					if (depth_q > 0) begin
						depth_q--;
						target = stack_q[depth_q];
					end
				end
				OPH_CALL: begin
					if (depth_q < 2) begin
						stack_q[depth_q] = pc1;
						depth_q++;
					end
					target = {1'b0, k};
					jumped = 1;
				end
				OPH_GOTOL, OPH_GOTOH: begin
					target = ins[8:0];
					jumped = 1;
				end
				OPH_MOVLW: w_q = k;
				OPH_IORLW: begin
					w_q = w | k;
					status_q[FLAG_Z] = (w_q == 0);
				end
				OPH_ANDLW: begin
					w_q = w & k;
					status_q[FLAG_Z] = (w_q == 0);
				end
				default: begin
					w_q = w ^ k;
					status_q[FLAG_Z] = (w_q == 0);
				end
			endcase
		end
		if (!jumped)
			target = pcl_hit ? {1'b0, pcl_val} : pc1;
		pc_q = target + {8'd0, skip};
		v.pc = pc_q;
		v.w = w_q;
		v.lat_a = lat_a_q;
		v.lat_b = lat_b_q;
		v.tris_a = tris_a_q;
		v.tris_b = tris_b_q;
		v.option = option_q;
		v.tmr_valid = tmr_hit;
		v.tmr_data = tmr_hit ? tmr_val : 8'd0;
		v.sleeping = sleep_q;
		views_due.push_back(v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		core_view_t want;
		if (!arst_n) begin
			pc_q = 0;
			w_q = 0;
			foreach (regs[i])
				regs[i] = 0;
			fsr_q = 0;
			status_q = STATUS_RESET;
			stack_q[0] = 0;
			stack_q[1] = 0;
			depth_q = 0;
			lat_a_q = 0;
			lat_b_q = 0;
			tris_a_q = TRIS_A_RESET;
			tris_b_q = TRIS_B_RESET;
			option_q = OPTION_RESET;
			sleep_q = 0;
			views_due.delete();
			errors = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (views_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result word %h", m_axis_tdata);
				end else begin
					want = views_due.pop_front();
					if (m_axis_tdata !== {7'd0, want}) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected %h, got %h", {7'd0, want},
								m_axis_tdata);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				execute_word(s_axis_tdata);
		end
		pending = views_due.size();
	end
endmodule
`default_nettype wire

/* bench/tb.sv */
// Testbench top for the baseline core: stimulus, idling phases and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import bmc_pkg::*;

	localparam int STALL_LIMIT = 2000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = 0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [63:0] m_axis_tdata;
	int          errors;
	int          pending;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          quiet_cycles = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	baseline_microcontroller_core u_dut (.*);

	bmc_checker u_check (.*);

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send_word(logic [11:0] ins);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {8'($urandom_range(255)), 8'($urandom_range(255)),
			4'($urandom_range(15)), ins};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [11:0] pick_instruction();
		logic [11:0] ins;
		ins = 12'($urandom);
		case ($urandom_range(9))
			0: ins[11:5] = {4'd0, 3'($urandom_range(1))};
			1: ins[4:0] = 5'($urandom_range(7));
			2: ins = {OPH_CALL, 8'($urandom)};
			3: ins = {OPH_RETLW, 8'($urandom)};
			default: ;
		endcase
		return ins;
	endfunction

	initial begin
		logic [11:0] directed [$];
		directed = '{12'h000, 12'hc00 | 12'h3f, 12'h002, 12'h005, 12'h006, 12'h007,
			12'hcff, 12'h024, 12'h020, 12'h1c0, 12'h0e1, 12'h0a2, 12'h023,
			12'h325, 12'h3e0, 12'h360, 12'h6e3, 12'h7e3, 12'h4ff, 12'h5ff,
			12'h904, 12'h905, 12'h906, 12'h800, 12'h8ff, 12'h803, 12'h004, 12'hbff,
			12'h26a, 12'hfff, 12'h040};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		foreach (directed[i])
			send_word(directed[i]);
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 34 : 58) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 34 : 58) : 0;
			repeat (300)
				send_word(pick_instruction());
			s_axis_tvalid <= 0;
			while (pending != 0)
				@(negedge clk);
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		while (pending != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire
